// File: rtl/fpr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared constants for the FIFO page replacement unit.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int unsigned FRAMES_DEF    = 16;
  localparam int unsigned PAGE_BITS_DEF = 16;

  localparam int unsigned CFG_W   = 5;
  localparam int unsigned COUNT_W = 32;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage : fpr_pkg
// ----------------------------------------------------------------------------
`default_nettype wire

// File: rtl/fpr_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpr_in_if
// Page reference channel: valid/ready with page number and end-of-sequence.
// ----------------------------------------------------------------------------
interface fpr_in_if
  import fpr_pkg::*;
#(
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
);

  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;
  logic                 last_reference;

  modport source (output valid, output page_number, output last_reference, input ready);
  modport sink   (input valid, input page_number, input last_reference, output ready);

endinterface : fpr_in_if
// ----------------------------------------------------------------------------
`default_nettype wire

// File: rtl/fpr_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpr_out_if
// Result channel: fault flag, evicted page, running fault count.
// ----------------------------------------------------------------------------
interface fpr_out_if
  import fpr_pkg::*;
#(
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
);

  logic                 valid;
  logic                 ready;
  logic                 fault;
  logic                 evicted_valid;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [COUNT_W-1:0]   fault_count;
  logic                 sequence_end;

  modport source (
    output valid, output fault, output evicted_valid, output evicted_page,
    output fault_count, output sequence_end, input ready
  );
  modport sink (
    input valid, input fault, input evicted_valid, input evicted_page,
    input fault_count, input sequence_end, output ready
  );

endinterface : fpr_out_if
// ----------------------------------------------------------------------------
`default_nettype wire

// File: rtl/fifo_page_replacement_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_page_replacement_unit
// FIFO page replacement over a small set of resident frames. Each reference
// is compared against all valid frames at once; misses fill or evict.
// ----------------------------------------------------------------------------
//  channel | direction | word
//  --------+-----------+--------------------------------------------------
//  in_ch   | in        | page_number, last_reference
//  out_ch  | out       | fault, evicted_valid, evicted_page, fault_count,
//          |           | sequence_end
//  cfg_    | in        | frames_in_use (write only)
//
//  One word per cycle unless the result stalls; a word passes the input stage
//  and output registers. The rate is set by the frame compare and update.
//  Synchronous reset clears frames, pointer, count and both stages;
//  frames_in_use resets to 16.
//  A stalled result holds in the output register and back-pressures the
//  input stage; a new word is taken whenever the input stage can move on.
// ----------------------------------------------------------------------------
module fifo_page_replacement_unit
  import fpr_pkg::*;
#(
  parameter int unsigned FRAMES    = FRAMES_DEF,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  fpr_in_if.sink                in_ch,
  fpr_out_if.source             out_ch,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data
);

  localparam int unsigned FILL_W = $clog2(FRAMES + 1);
  localparam int unsigned IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

  // configuration
  logic [CFG_W-1:0] cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // input stage
  logic                 s1_valid_r;
  logic [PAGE_BITS-1:0] s1_page_r;
  logic                 s1_last_r;
  logic                 s1_adv;
  logic                 s1_fire;
  logic                 in_take;

  assign s1_adv      = !out_ch.valid || out_ch.ready;
  assign s1_fire     = s1_valid_r && s1_adv;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_page_r <= in_ch.page_number;
      s1_last_r <= in_ch.last_reference;
    end
  end

  // frame state
  logic [PAGE_BITS-1:0] frame_pages_r [FRAMES];
  logic [FRAMES-1:0]    frame_valid_r, frame_valid_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [IDX_W-1:0]     oldest_r, oldest_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;

  logic                 hit;
  logic                 do_fill;
  logic                 do_evict;
  logic [CMP_W-1:0]     cap_eff;
  logic [CMP_W-1:0]     fill_ext;
  logic [CMP_W-1:0]     slot_ext;
  logic [CMP_W-1:0]     slot_inc;
  logic [IDX_W-1:0]     slot_idx;
  logic [IDX_W-1:0]     fill_idx;
  logic [IDX_W-1:0]     wr_idx;
  logic [PAGE_BITS-1:0] victim;

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < FRAMES; i++) begin
      if (frame_valid_r[i] && (frame_pages_r[i] == s1_page_r)) begin
        hit = 1'b1;
      end
    end

    cap_eff = CMP_W'(cfg_r);
    if (cap_eff == '0) begin
      cap_eff = CMP_W'(1);
    end
    if (cap_eff > CMP_W'(FRAMES)) begin
      cap_eff = CMP_W'(FRAMES);
    end

    fill_ext = CMP_W'(fill_r);
    do_fill  = !hit && (fill_ext < cap_eff);
    do_evict = !hit && !do_fill;

    slot_ext = CMP_W'(oldest_r);
    if (slot_ext >= fill_ext) begin
      slot_ext = '0;
    end
    slot_inc = slot_ext + CMP_W'(1);
    if (slot_inc >= fill_ext) begin
      slot_inc = '0;
    end
    slot_idx = slot_ext[IDX_W-1:0];
    fill_idx = fill_ext[IDX_W-1:0];
    wr_idx   = do_fill ? fill_idx : slot_idx;
    victim   = frame_pages_r[slot_idx];
  end

  always_comb begin
    frame_valid_nxt = frame_valid_r;
    fill_nxt        = fill_r;
    oldest_nxt      = oldest_r;
    count_nxt       = count_r;
    if (s1_fire) begin
      if (s1_last_r) begin
        frame_valid_nxt = '0;
        fill_nxt        = '0;
        oldest_nxt      = '0;
        count_nxt       = '0;
      end else begin
        if (do_fill) begin
          frame_valid_nxt[fill_idx] = 1'b1;
          fill_nxt                  = fill_r + FILL_W'(1);
        end
        if (do_evict) begin
          oldest_nxt = slot_inc[IDX_W-1:0];
        end
        if (!hit && (count_r != COUNT_MAX)) begin
          count_nxt = count_r + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      fill_r        <= '0;
      oldest_r      <= '0;
      count_r       <= '0;
    end else begin
      frame_valid_r <= frame_valid_nxt;
      fill_r        <= fill_nxt;
      oldest_r      <= oldest_nxt;
      count_r       <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && !hit) begin
      frame_pages_r[wr_idx] <= s1_page_r;
    end
  end

  // result register
  logic                 out_valid_r;
  logic                 out_fault_r;
  logic                 out_evict_r;
  logic [PAGE_BITS-1:0] out_page_r;
  logic [COUNT_W-1:0]   out_count_r;
  logic                 out_end_r;
  logic [COUNT_W-1:0]   count_seen;

  assign count_seen = (!hit && (count_r != COUNT_MAX)) ? count_r + COUNT_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_fault_r <= !hit;
      out_evict_r <= do_evict;
      out_page_r  <= do_evict ? victim : '0;
      out_count_r <= count_seen;
      out_end_r   <= s1_last_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fault         = out_fault_r;
  assign out_ch.evicted_valid = out_evict_r;
  assign out_ch.evicted_page  = out_page_r;
  assign out_ch.fault_count   = out_count_r;
  assign out_ch.sequence_end  = out_end_r;

  // checks
  a_fill_range : assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(fill_r) <= CMP_W'(FRAMES))
    else $error("fill count beyond frame count");

  a_valid_count : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(frame_valid_r) == int'(fill_r))
    else $error("valid bits disagree with fill count");

  a_oldest_range : assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != '0) |-> (CMP_W'(oldest_r) < CMP_W'(fill_r)))
    else $error("oldest pointer past filled frames");

  a_evict_fault : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_evict_r || out_fault_r))
    else $error("eviction without fault");

  a_seq_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> ((fill_r == '0) && (count_r == '0) && (frame_valid_r == '0)))
    else $error("state not cleared after sequence end");

endmodule : fifo_page_replacement_unit
// ----------------------------------------------------------------------------
`default_nettype wire
